/* hw/rtl/srrw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srrw_pkg
// Shared constants and types for the selective repeat receive window.
// ----------------------------------------------------------------------------
package srrw_pkg;

  localparam int WIN_SLOTS     = 8;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int SEQ_W         = 32;
  localparam int WORD_W        = 32;
  localparam int SLOT_W        = $clog2(WIN_SLOTS);
  // payload bits kept in a slot; the result word is 32 bits wide
  localparam int STORE_W       = (PAYLOAD_WIDTH < WORD_W) ? PAYLOAD_WIDTH : WORD_W;

  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACK,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic              wr;
    logic [SLOT_W-1:0] wr_idx;
    logic              shift;
  } chain_ctrl_t;

endpackage
`default_nettype wire

/* hw/rtl/srrw_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srrw_cell
// One window slot. Loads a received word, or takes its upper neighbor's
// contents when the window slides down by one.
// ----------------------------------------------------------------------------
module srrw_cell
  import srrw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               shift,
  input  wire logic               wr_en,
  input  wire logic [STORE_W-1:0] wr_payload,
  input  wire logic               nb_valid,
  input  wire logic [STORE_W-1:0] nb_payload,
  output logic                    valid,
  output logic [STORE_W-1:0]      payload
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= nb_valid;
    end else if (wr_en) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      payload <= nb_payload;
    end else if (wr_en) begin
      payload <= wr_payload;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/srrw_chain.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srrw_chain
// Row of window cells. Cell k holds sequence number expected_seq + k, so
// cell 0 is always the base slot.
// ----------------------------------------------------------------------------
module srrw_chain
  import srrw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire chain_ctrl_t        ctrl,
  input  wire logic [STORE_W-1:0] wr_payload,
  output logic                    head_valid,
  output logic [STORE_W-1:0]      head_payload,
  output logic                    second_valid
);

  logic               valid_q   [WIN_SLOTS];
  logic [STORE_W-1:0] payload_q [WIN_SLOTS];

  for (genvar k = 0; k < WIN_SLOTS; k++) begin : g_cell
    logic               nb_valid;
    logic [STORE_W-1:0] nb_payload;

    if (k == WIN_SLOTS - 1) begin : g_top
      assign nb_valid   = 1'b0;
      assign nb_payload = '0;
    end else begin : g_mid
      assign nb_valid   = valid_q[k+1];
      assign nb_payload = payload_q[k+1];
    end

    srrw_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (ctrl.shift),
      .wr_en      (ctrl.wr && (ctrl.wr_idx == SLOT_W'(k))),
      .wr_payload (wr_payload),
      .nb_valid   (nb_valid),
      .nb_payload (nb_payload),
      .valid      (valid_q[k]),
      .payload    (payload_q[k])
    );
  end

  assign head_valid   = valid_q[0];
  assign head_payload = payload_q[0];
  assign second_valid = valid_q[1];

endmodule
`default_nettype wire

/* hw/rtl/selective_repeat_receive_window.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// Receiver side of selective repeat: acknowledges packets, buffers the ones
// inside the window and delivers stored words in sequence order.
// ----------------------------------------------------------------------------
//  channel  handshake         payload
//  in       in_valid/ready    in_seq, in_payload
//  out      out_valid/ready   out_kind, out_seq, out_payload, out_last
//
// One packet at a time. A packet is accepted in ST_IDLE, its ack goes out from
// ST_ACK, then ST_DRAIN gives one delivery per cycle while the out channel is free
// and the base cell holds data (the cell row shifts by one per delivery).
// An out-of-window packet above the top is taken in ST_IDLE and gives no beat.
// A stalled out beat holds the row and the sequencer. Reset clears all cells
// at once; no sweep is needed.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window
  import srrw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [SEQ_W-1:0]  in_seq,
  input  wire logic [WORD_W-1:0] in_payload,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_kind,
  output logic [SEQ_W-1:0]       out_seq,
  output logic [WORD_W-1:0]      out_payload,
  output logic                   out_last
);

  state_t             state, state_next;
  logic [SEQ_W-1:0]   expected_seq;
  logic [SEQ_W-1:0]   ack_seq;
  logic               ack_last;

  logic               head_valid, second_valid;
  logic [STORE_W-1:0] head_payload;
  chain_ctrl_t        ctrl;

  logic               accept, out_free, out_load;
  logic [SEQ_W-1:0]   win_top, offset;
  logic               below, in_window;

  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign win_top   = expected_seq + SEQ_W'(WIN_SLOTS);
  assign offset    = in_seq - expected_seq;
  assign below     = in_seq < expected_seq;
  assign in_window = !below && (in_seq < win_top);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (below || in_window)) begin
          state_next = ST_ACK;
        end
      end
      ST_ACK: begin
        if (out_free) begin
          state_next = ack_last ? ST_IDLE : ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_free && !second_valid) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready    = 1'b0;
    out_load    = 1'b0;
    ctrl.wr     = 1'b0;
    ctrl.wr_idx = offset[SLOT_W-1:0];
    ctrl.shift  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctrl.wr  = accept && in_window;
      end
      ST_ACK: begin
        out_load = out_free;
      end
      ST_DRAIN: begin
        out_load   = out_free;
        ctrl.shift = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      expected_seq <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DRAIN && out_free) begin
        expected_seq <= expected_seq + SEQ_W'(1);
      end
    end
  end

  // pending ack; it is last unless the packet filled the base cell
  always_ff @(posedge clk) begin
    if (accept) begin
      ack_seq  <= in_seq;
      ack_last <= below || (offset[SLOT_W-1:0] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ST_ACK) begin
        out_kind    <= KIND_ACK;
        out_seq     <= ack_seq;
        out_payload <= '0;
        out_last    <= ack_last;
      end else begin
        out_kind    <= KIND_DELIVER;
        out_seq     <= expected_seq;
        out_payload <= WORD_W'(head_payload);
        out_last    <= !second_valid;
      end
    end
  end

  srrw_chain u_chain (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .wr_payload   (in_payload[STORE_W-1:0]),
    .head_valid   (head_valid),
    .head_payload (head_payload),
    .second_valid (second_valid)
  );

  // the base cell is only consumed while it holds data
  logic unused_head;
  assign unused_head = head_valid;

endmodule
`default_nettype wire

/* hw/rtl/srrw_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srrw_checker
// Port-level checks for the selective repeat receive window.
// ----------------------------------------------------------------------------
module srrw_checker
  import srrw_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic [SEQ_W-1:0]  in_seq,
  input wire logic [WORD_W-1:0] in_payload,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              out_kind,
  input wire logic [SEQ_W-1:0]  out_seq,
  input wire logic [WORD_W-1:0] out_payload,
  input wire logic              out_last
);

  logic unused_in;
  assign unused_in = in_valid ^ (^in_seq) ^ (^in_payload);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_seq) && $stable(out_kind)
      && $stable(out_payload) && $stable(out_last))
    else $error("out beat changed while stalled");

  a_ack_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_ACK |-> out_payload == '0)
    else $error("ack beat carries a payload");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> !in_ready)
    else $error("new packet taken while its results are still going out");

  a_deliver_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_kind == KIND_DELIVER && !out_last
      |=> out_valid && out_kind == KIND_DELIVER && out_seq == $past(out_seq) + SEQ_W'(1))
    else $error("deliveries out of sequence");

endmodule

bind selective_repeat_receive_window srrw_checker u_srrw_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_seq      (in_seq),
  .in_payload  (in_payload),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_kind    (out_kind),
  .out_seq     (out_seq),
  .out_payload (out_payload),
  .out_last    (out_last)
);
`default_nettype wire

/* bench/tb_selective_repeat_receive_window.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_selective_repeat_receive_window
// Self-checking bench for the selective repeat receive window. A local window
// model predicts the acks and in-order deliveries of every accepted packet;
// each out beat is checked against the oldest prediction. Directed packets
// cover in-order, below-window, above-window, reordered and duplicate cases,
// then random packets run with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_selective_repeat_receive_window;
  import srrw_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 120;
  localparam logic [WORD_W-1:0] PAY_MASK = {WORD_W{1'b1}} >> (WORD_W - STORE_W);

  typedef struct {
    logic              kind;
    logic [SEQ_W-1:0]  seq;
    logic [WORD_W-1:0] word;
    logic              last;
  } beat_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [SEQ_W-1:0]  in_seq;
  logic [WORD_W-1:0] in_payload;
  logic              out_valid;
  logic              out_ready;
  logic              out_kind;
  logic [SEQ_W-1:0]  out_seq;
  logic [WORD_W-1:0] out_payload;
  logic              out_last;

  // window model
  logic              held_valid [WIN_SLOTS];
  logic [WORD_W-1:0] held_word [WIN_SLOTS];
  logic [SEQ_W-1:0]  next_seq;
  int                head_slot;

  beat_t beats_due[$];
  beat_t staged;
  bit    staged_ok;

  int errors      = 0;
  int cycle_count = 0;
  bit gaps_on     = 1'b1;
  int hold_asks   = 0;

  selective_repeat_receive_window uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_seq      (in_seq),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_seq     (out_seq),
    .out_payload (out_payload),
    .out_last    (out_last)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("selective_repeat_receive_window test failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // holds back one beat so the last one of a packet can be flagged
  function automatic void stage_beat(input logic kind, input logic [SEQ_W-1:0] seq,
                                     input logic [WORD_W-1:0] word);
    if (staged_ok) beats_due.push_back(staged);
    staged.kind = kind;
    staged.seq  = seq;
    staged.word = word;
    staged.last = 1'b0;
    staged_ok   = 1'b1;
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < WIN_SLOTS; i++) begin
      held_valid[i] = 1'b0;
      held_word[i]  = '0;
    end
    next_seq  = '0;
    head_slot = 0;
  endfunction

  function automatic void window_accept(input logic [SEQ_W-1:0] seq,
                                        input logic [WORD_W-1:0] word);
    logic [SEQ_W-1:0] top;
    int               slot;
    top       = next_seq + SEQ_W'(WIN_SLOTS);
    staged_ok = 1'b0;
    if (seq < next_seq) begin
      stage_beat(KIND_ACK, seq, '0);
    end else if (seq < top) begin
      stage_beat(KIND_ACK, seq, '0);
      slot = int'(seq % SEQ_W'(WIN_SLOTS));
      held_valid[slot] = 1'b1;
      held_word[slot]  = word & PAY_MASK;
    end
    for (int i = 0; i < WIN_SLOTS; i++) begin
      if (!held_valid[head_slot]) break;
      stage_beat(KIND_DELIVER, next_seq, held_word[head_slot]);
      held_valid[head_slot] = 1'b0;
      held_word[head_slot]  = '0;
      head_slot = (head_slot + 1) % WIN_SLOTS;
      next_seq  = next_seq + 1'b1;
    end
    if (staged_ok) begin
      staged.last = 1'b1;
      beats_due.push_back(staged);
    end
  endfunction

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic [WORD_W-1:0] word);
    int gap;
    gap = (gaps_on && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_seq     <= seq;
    in_payload <= word;
    do @(posedge clk); while (!in_ready);
    window_accept(seq, word);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
  endtask

  // receiver side: random stalls plus long hold-offs on request
  initial begin : out_side
    int pause;
    int hold_seen;
    out_ready = 1'b0;
    pause     = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        pause     = LONG_HOLD;
      end else if (pause == 0 && gaps_on && $urandom_range(0, 3) == 0) begin
        pause = pick_gap();
      end
      if (rst || pause > 0) begin
        out_ready <= 1'b0;
        if (pause > 0) pause--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (beats_due.size() == 0) begin
        $error("unexpected beat: kind %0d seq %h payload %h last %0d",
               out_kind, out_seq, out_payload, out_last);
        errors++;
      end else begin
        want = beats_due.pop_front();
        if (out_kind !== want.kind) begin
          $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
          errors++;
        end
        if (out_seq !== want.seq) begin
          $error("out_seq: expected %h, got %h", want.seq, out_seq);
          errors++;
        end
        if (out_payload !== want.word) begin
          $error("out_payload: expected %h, got %h", want.word, out_payload);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %0d, got %0d", want.last, out_last);
          errors++;
        end
      end
    end
  end

  task automatic test_in_order();
    send_packet(32'd0, 32'h0000_0000);
    send_packet(32'd1, 32'hFFFF_FFFF);
    send_packet(32'd2, 32'hA5A5_5A5A);
    wait_drained();
  endtask

  // already delivered: ack again, nothing stored
  task automatic test_below_window();
    send_packet(32'd0, 32'h1234_5678);
    send_packet(next_seq - 1'b1, 32'h8765_4321);
    wait_drained();
  endtask

  // at or past the top: silently dropped
  task automatic test_above_window();
    send_packet(next_seq + SEQ_W'(WIN_SLOTS), 32'hDEAD_BEEF);
    send_packet(32'hFFFF_FFFF, 32'h5555_5555);
    send_packet(32'h8000_0000, 32'hAAAA_AAAA);
    wait_drained();
  endtask

  // fill the window back to front with one overwrite, then close the gap
  task automatic test_reorder_duplicate();
    logic [SEQ_W-1:0] low;
    low = next_seq;
    for (int k = WIN_SLOTS - 1; k >= 1; k--)
      send_packet(low + SEQ_W'(k), $urandom());
    send_packet(low + 3, 32'h0F0F_F0F0);
    send_packet(low, 32'hC3C3_3C3C);
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_asks++;
    for (int i = 0; i < 16; i++)
      send_packet(next_seq + SEQ_W'($urandom_range(0, WIN_SLOTS - 1)), $urandom());
    wait_drained();
    gaps_on = 1'b1;
  endtask

  task automatic test_random(input int count);
    int               pick;
    logic [SEQ_W-1:0] seq;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 75)
        seq = next_seq + SEQ_W'($urandom_range(0, WIN_SLOTS - 1));
      else if (pick < 87)
        seq = next_seq - SEQ_W'($urandom_range(1, 20));
      else if (pick < 94)
        seq = next_seq + SEQ_W'(WIN_SLOTS + $urandom_range(0, 20));
      else
        seq = $urandom();
      send_packet(seq, $urandom());
    end
    gaps_on = 1'b1;
    wait_drained();
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_seq     = '0;
    in_payload = '0;
    clear_window();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_in_order();
    test_below_window();
    test_above_window();
    test_reorder_duplicate();
    test_backpressure();
    test_random(240);

    // an above-window packet may still be in flight with no beat to wait on
    repeat (WIN_SLOTS + 4) @(posedge clk);
    if (errors == 0 && beats_due.size() == 0) begin
      $display("selective_repeat_receive_window test passed");
    end else begin
      $display("selective_repeat_receive_window test failed");
    end
    $finish;
  end

endmodule
